@@ rtl/core/gaf_pkg.sv @@
// Shared types, constants and helpers of the grid A* path finder.
package gaf_pkg;

   // grid geometry
   localparam int GRID_W  = 64;
   localparam int GRID_H  = 32;
   localparam int X_W     = $clog2(GRID_W);
   localparam int Y_W     = $clog2(GRID_H);
   localparam int ADDR_W  = X_W + Y_W;
   localparam int COL_W   = X_W + 1;
   localparam int ROW_W   = Y_W + 1;
   localparam int COST_W  = ADDR_W + 1;
   localparam int LEN_W   = 11;
   localparam int DIR_W   = 3;
   localparam int WALL_W  = 4;
   localparam int CMD_W   = 2;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'd1;
   localparam logic [COL_W-1:0] COLS_RESET = COL_W'(40);
   localparam logic [ROW_W-1:0] ROWS_RESET = ROW_W'(30);

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SOLVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   // parent direction codes
   localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;

   // neighbour visiting order
   localparam logic [1:0] NB_LEFT  = 2'd0;
   localparam logic [1:0] NB_UP    = 2'd1;
   localparam logic [1:0] NB_RIGHT = 2'd2;
   localparam logic [1:0] NB_DOWN  = 2'd3;

   // wall bit positions
   localparam int WALL_TOP    = 0;
   localparam int WALL_RIGHT  = 1;
   localparam int WALL_BOTTOM = 2;
   localparam int WALL_LEFT   = 3;

   typedef struct packed {
      logic [COST_W-1:0] cost;   // g + 1, zero when unreached
      logic [DIR_W-1:0]  par;
      logic              closed;
   } node_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_CLEAR,
      ST_SEED,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK,
      ST_NB_ADDR,
      ST_NB_EVAL,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic init_clear;
      logic node_clear;
      logic wall_wr;
      logic rd_issue;
      logic solve_start;
      logic seed;
      logic scan_start;
      logic scan_step;
      logic pick_close;
      logic set_found;
      logic nb_issue;
      logic nb_update;
      logic nb_next;
      logic rsp_load;
      logic rsp_read;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic clr_last;
      logic range_bad;
      logic scan_last;
      logic any_open;
      logic at_goal;
      logic nb_ok;
      logic dir_last;
   } ctrl_sts_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                   input logic [Y_W-1:0] y);
      cell_addr = {y, x};
   endfunction

   function automatic logic [X_W-1:0] abs_diff_x(input logic [X_W-1:0] a,
                                                 input logic [X_W-1:0] b);
      abs_diff_x = (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [Y_W-1:0] abs_diff_y(input logic [Y_W-1:0] a,
                                                 input logic [Y_W-1:0] b);
      abs_diff_y = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

@@ rtl/core/gaf_ctrl.sv @@
// Controller state machine of the grid A* path finder.
module gaf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [gaf_pkg::CMD_W-1:0] req_cmd,
   input  gaf_pkg::ctrl_sts_type sts,
   output gaf_pkg::ctrl_cmd_type cmd
);
   import gaf_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           accept;

   assign req_stall = !((state_ff == ST_IDLE) && sts.slot_free);
   assign accept    = req_valid && !req_stall;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_clear = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_LOAD: begin
                     cmd.wall_wr  = 1'b1;
                     cmd.rsp_load = 1'b1;
                  end
                  CMD_SOLVE: begin
                     cmd.solve_start = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  CMD_READ: begin
                     cmd.rd_issue = 1'b1;
                     state_in     = ST_READ;
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_read = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_CLEAR: begin
            cmd.node_clear = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            if (sts.range_bad) begin
               state_in = ST_DONE;
            end else begin
               cmd.seed       = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            priority if (!sts.any_open) begin
               state_in = ST_DONE;
            end else if (sts.at_goal) begin
               cmd.set_found = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.pick_close = 1'b1;
               state_in       = ST_NB_ADDR;
            end
         end
         ST_NB_ADDR: begin
            priority if (sts.nb_ok) begin
               cmd.nb_issue = 1'b1;
               state_in     = ST_NB_EVAL;
            end else if (sts.dir_last) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               cmd.nb_next = 1'b1;
            end
         end
         ST_NB_EVAL: begin
            cmd.nb_update = 1'b1;
            if (sts.dir_last) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               cmd.nb_next = 1'b1;
               state_in    = ST_NB_ADDR;
            end
         end
         ST_DONE: begin
            if (sts.slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

@@ rtl/core/gaf_dp.sv @@
// Datapath of the grid A* path finder: grid memories, scan, expansion and result register.
module gaf_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gaf_pkg::X_W-1:0]       req_cell_x,
   input  logic [gaf_pkg::Y_W-1:0]       req_cell_y,
   input  logic [gaf_pkg::WALL_W-1:0]    req_wall_bits,
   input  logic [gaf_pkg::X_W-1:0]       req_start_x,
   input  logic [gaf_pkg::Y_W-1:0]       req_start_y,
   input  logic [gaf_pkg::X_W-1:0]       req_end_x,
   input  logic [gaf_pkg::Y_W-1:0]       req_end_y,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [gaf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gaf_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [gaf_pkg::LEN_W-1:0]     rsp_path_length,
   output logic [gaf_pkg::DIR_W-1:0]     rsp_parent_dir,
   output logic                          rsp_cell_reached,
   input  gaf_pkg::ctrl_cmd_type         cmd,
   output gaf_pkg::ctrl_sts_type         sts
);
   import gaf_pkg::*;

   localparam int NCELLS = GRID_W * GRID_H;
   localparam logic [COL_W-1:0] COL_MAX = COL_W'(GRID_W);
   localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(GRID_H);

   // memories
   logic [WALL_W-1:0] wall_mem [NCELLS];
   node_type          node_mem [NCELLS];

   logic [COL_W-1:0]  cols_ff;
   logic [ROW_W-1:0]  rows_ff;
   logic [COL_W-1:0]  cols_eff;
   logic [ROW_W-1:0]  rows_eff;

   logic [ADDR_W-1:0] ctr_ff;
   logic [X_W-1:0]    sx_ff, ex_ff;
   logic [Y_W-1:0]    sy_ff, ey_ff;
   logic              rd_ok_ff;

   logic [X_W-1:0]    scan_x_ff, p_x_ff, bx_ff;
   logic [Y_W-1:0]    scan_y_ff, p_y_ff, by_ff;
   logic              p_valid_ff, any_ff;
   logic [COST_W-1:0] bf_ff, bcost_ff;
   logic [DIR_W-1:0]  bpar_ff;

   logic [1:0]        dir_ff;
   logic [ADDR_W-1:0] nb_addr_ff;
   logic [1:0]        nb_bit_ff;
   logic [DIR_W-1:0]  nb_pdir_ff;

   logic              last_found_ff;
   logic [LEN_W-1:0]  last_len_ff;

   logic              rsp_valid_ff, rsp_found_ff, rsp_reached_ff;
   logic [LEN_W-1:0]  rsp_len_ff;
   logic [DIR_W-1:0]  rsp_dir_ff;

   node_type          node_rd_ff;
   logic [WALL_W-1:0] wall_rd_ff;

   logic              cell_ok;
   logic              node_we, wall_we;
   logic [ADDR_W-1:0] node_wa, node_ra, wall_wa;
   node_type          node_wd, close_wd, upd_wd;
   logic [WALL_W-1:0] wall_wd;

   logic              nb_ok;
   logic [X_W-1:0]    nb_x;
   logic [Y_W-1:0]    nb_y;
   logic [1:0]        nb_bit;
   logic [DIR_W-1:0]  nb_pdir;
   logic [COST_W-1:0] g_next, f_cand, len_raw;
   logic              cand_ok, upd_ok, scan_last;

   // clamp active dimensions
   always_comb begin
      priority if (cols_ff == '0)     cols_eff = COL_W'(1);
      else if (cols_ff > COL_MAX)     cols_eff = COL_MAX;
      else                            cols_eff = cols_ff;
      priority if (rows_ff == '0)     rows_eff = ROW_W'(1);
      else if (rows_ff > ROW_MAX)     rows_eff = ROW_MAX;
      else                            rows_eff = rows_ff;
   end

   assign cell_ok = ({1'b0, req_cell_x} < cols_eff) && ({1'b0, req_cell_y} < rows_eff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLS: cols_ff <= csr_wdata[COL_W-1:0];
            CSR_ROWS: rows_ff <= csr_wdata[ROW_W-1:0];
            default:  ;
         endcase
      end
   end

   // neighbour of the current cell in the present direction
   always_comb begin
      nb_ok   = 1'b0;
      nb_x    = bx_ff;
      nb_y    = by_ff;
      nb_bit  = 2'(WALL_RIGHT);
      nb_pdir = DIR_RIGHT;
      unique case (dir_ff)
         NB_LEFT: begin
            nb_ok   = (bx_ff != '0);
            nb_x    = bx_ff - X_W'(1);
            nb_bit  = 2'(WALL_RIGHT);
            nb_pdir = DIR_RIGHT;
         end
         NB_UP: begin
            nb_ok   = (by_ff != '0);
            nb_y    = by_ff - Y_W'(1);
            nb_bit  = 2'(WALL_BOTTOM);
            nb_pdir = DIR_DOWN;
         end
         NB_RIGHT: begin
            nb_ok   = ({1'b0, bx_ff} + COL_W'(1)) < cols_eff;
            nb_x    = bx_ff + X_W'(1);
            nb_bit  = 2'(WALL_LEFT);
            nb_pdir = DIR_LEFT;
         end
         default: begin
            nb_ok   = ({1'b0, by_ff} + ROW_W'(1)) < rows_eff;
            nb_y    = by_ff + Y_W'(1);
            nb_bit  = 2'(WALL_TOP);
            nb_pdir = DIR_UP;
         end
      endcase
   end

   assign g_next = bcost_ff + COST_W'(1);
   assign upd_ok = !wall_rd_ff[nb_bit_ff] && !node_rd_ff.closed &&
                   ((node_rd_ff.cost == '0) || (g_next < node_rd_ff.cost));

   assign close_wd = '{cost: bcost_ff, par: bpar_ff, closed: 1'b1};
   assign upd_wd   = '{cost: g_next, par: nb_pdir_ff, closed: 1'b0};

   // select memory ports
   always_comb begin
      node_we = 1'b0;
      node_wa = ctr_ff;
      node_wd = '0;
      priority if (cmd.init_clear || cmd.node_clear) begin
         node_we = 1'b1;
      end else if (cmd.seed) begin
         node_we = 1'b1;
         node_wa = cell_addr(sx_ff, sy_ff);
         node_wd = '{cost: COST_W'(1), par: DIR_NONE, closed: 1'b0};
      end else if (cmd.pick_close) begin
         node_we = 1'b1;
         node_wa = cell_addr(bx_ff, by_ff);
         node_wd = close_wd;
      end else if (cmd.nb_update) begin
         node_we = upd_ok;
         node_wa = nb_addr_ff;
         node_wd = upd_wd;
      end else begin
         node_we = 1'b0;
      end

      priority if (cmd.rd_issue)       node_ra = cell_addr(req_cell_x, req_cell_y);
      else if (cmd.scan_step)          node_ra = cell_addr(scan_x_ff, scan_y_ff);
      else                             node_ra = cell_addr(nb_x, nb_y);

      wall_we = cmd.init_clear || (cmd.wall_wr && cell_ok);
      wall_wa = cmd.init_clear ? ctr_ff : cell_addr(req_cell_x, req_cell_y);
      wall_wd = cmd.init_clear ? '1 : req_wall_bits;
   end

   // grid memories with registered read
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      node_rd_ff <= node_mem[node_ra];
      if (wall_we) begin
         wall_mem[wall_wa] <= wall_wd;
      end
      wall_rd_ff <= wall_mem[cell_addr(nb_x, nb_y)];
   end

   // clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
      end else if (cmd.solve_start) begin
         ctr_ff <= '0;
      end else if (cmd.init_clear || cmd.node_clear) begin
         ctr_ff <= ctr_ff + ADDR_W'(1);
      end
   end

   // capture request fields
   always_ff @(posedge clock) begin
      if (cmd.solve_start) begin
         sx_ff <= req_start_x;
         sy_ff <= req_start_y;
         ex_ff <= req_end_x;
         ey_ff <= req_end_y;
      end
      if (cmd.rd_issue) begin
         rd_ok_ff <= cell_ok;
      end
   end

   // scan address walk, columns outer and rows inner
   assign scan_last = ({1'b0, scan_x_ff} == cols_eff - COL_W'(1)) &&
                      ({1'b0, scan_y_ff} == rows_eff - ROW_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= cmd.scan_step;
      end
      if (cmd.scan_start) begin
         scan_x_ff <= '0;
         scan_y_ff <= '0;
      end else if (cmd.scan_step) begin
         if ({1'b0, scan_y_ff} == rows_eff - ROW_W'(1)) begin
            scan_y_ff <= '0;
            scan_x_ff <= scan_x_ff + X_W'(1);
         end else begin
            scan_y_ff <= scan_y_ff + Y_W'(1);
         end
      end
      p_x_ff <= scan_x_ff;
      p_y_ff <= scan_y_ff;
   end

   // keep the least (f, x, y) open cell
   assign cand_ok = p_valid_ff && (node_rd_ff.cost != '0) && !node_rd_ff.closed;
   assign f_cand  = (node_rd_ff.cost - COST_W'(1)) +
                    COST_W'(abs_diff_x(p_x_ff, ex_ff)) +
                    COST_W'(abs_diff_y(p_y_ff, ey_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         any_ff <= 1'b0;
      end else if (cand_ok) begin
         any_ff <= 1'b1;
      end
      if (cand_ok && (!any_ff || (f_cand < bf_ff))) begin
         bf_ff    <= f_cand;
         bx_ff    <= p_x_ff;
         by_ff    <= p_y_ff;
         bcost_ff <= node_rd_ff.cost;
         bpar_ff  <= node_rd_ff.par;
      end
   end

   // neighbour direction and pending update
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= NB_LEFT;
      end else if (cmd.pick_close) begin
         dir_ff <= NB_LEFT;
      end else if (cmd.nb_next) begin
         dir_ff <= dir_ff + 2'd1;
      end
      if (cmd.nb_issue) begin
         nb_addr_ff <= cell_addr(nb_x, nb_y);
         nb_bit_ff  <= nb_bit;
         nb_pdir_ff <= nb_pdir;
      end
   end

   // last solve status
   assign len_raw = bcost_ff - COST_W'(1);

   always_ff @(posedge clock) begin
      if (reset || cmd.solve_start) begin
         last_found_ff <= 1'b0;
         last_len_ff   <= '0;
      end else if (cmd.set_found) begin
         last_found_ff <= 1'b1;
         last_len_ff   <= (len_raw > COST_W'(2047)) ? LEN_W'(2047) : len_raw[LEN_W-1:0];
      end
   end

   // result register, freed when the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_found_ff   <= last_found_ff;
         rsp_len_ff     <= last_len_ff;
         rsp_dir_ff     <= (cmd.rsp_read && rd_ok_ff) ? node_rd_ff.par : DIR_NONE;
         rsp_reached_ff <= cmd.rsp_read && rd_ok_ff && (node_rd_ff.cost != '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_path_length  = rsp_len_ff;
   assign rsp_parent_dir   = rsp_dir_ff;
   assign rsp_cell_reached = rsp_reached_ff;

   // status to the controller
   assign sts.slot_free = !rsp_valid_ff || !rsp_stall;
   assign sts.clr_last  = (ctr_ff == '1);
   assign sts.range_bad = ({1'b0, sx_ff} >= cols_eff) || ({1'b0, sy_ff} >= rows_eff) ||
                          ({1'b0, ex_ff} >= cols_eff) || ({1'b0, ey_ff} >= rows_eff);
   assign sts.scan_last = scan_last;
   assign sts.any_open  = any_ff;
   assign sts.at_goal   = (bx_ff == ex_ff) && (by_ff == ey_ff);
   assign sts.nb_ok     = nb_ok;
   assign sts.dir_last  = (dir_ff == NB_DOWN);

endmodule

@@ rtl/core/grid_astar_path_finder.sv @@
// Top level of the grid A* path finder: controller and datapath.
// A wall load or a no-operation beat is answered from the idle state, a parent read through
// the read state. A solve clears the costs, parents and closed marks of all 2048 cells,
// seeds the start if start and end lie in the active grid, and then for each expanded cell
// scans the active node memory one cell per cycle and visits four neighbours through its
// single read port; the input stays stalled until the result beat is loaded. After reset the
// wall memory is set to all walls in a pass over all 2048 cells during which no request is
// taken; configuration writes are always taken.
module grid_astar_path_finder (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gaf_pkg::CMD_W-1:0]      req_cmd,
   input  logic [gaf_pkg::X_W-1:0]        req_cell_x,
   input  logic [gaf_pkg::Y_W-1:0]        req_cell_y,
   input  logic [gaf_pkg::WALL_W-1:0]     req_wall_bits,
   input  logic [gaf_pkg::X_W-1:0]        req_start_x,
   input  logic [gaf_pkg::Y_W-1:0]        req_start_y,
   input  logic [gaf_pkg::X_W-1:0]        req_end_x,
   input  logic [gaf_pkg::Y_W-1:0]        req_end_y,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [gaf_pkg::LEN_W-1:0]      rsp_path_length,
   output logic [gaf_pkg::DIR_W-1:0]      rsp_parent_dir,
   output logic                           rsp_cell_reached,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gaf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gaf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gaf_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   assign csr_ready = 1'b1;

   gaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .sts       (sts),
      .cmd       (cmd)
   );

   gaf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_wall_bits    (req_wall_bits),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_path_length  (rsp_path_length),
      .rsp_parent_dir   (rsp_parent_dir),
      .rsp_cell_reached (rsp_cell_reached),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

@@ rtl/core/gaf_checker.sv @@
// Port-level checks of the grid A* path finder and their binding.
module gaf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_found,
   input logic [gaf_pkg::LEN_W-1:0]     rsp_path_length,
   input logic [gaf_pkg::DIR_W-1:0]     rsp_parent_dir,
   input logic                          rsp_cell_reached
);
   import gaf_pkg::*;

   // hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // stall input while the wall memory is set up
   a_init_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during setup pass");

   // no length without a found path
   a_len_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_path_length == '0)
      else $error("path length without found");

   // parent only on reached cells
   a_dir_reached: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_parent_dir != DIR_NONE) |-> rsp_cell_reached)
      else $error("parent direction on unreached cell");

   // legal direction codes
   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_parent_dir == DIR_NONE) || (rsp_parent_dir == DIR_LEFT) ||
                    (rsp_parent_dir == DIR_UP) || (rsp_parent_dir == DIR_RIGHT) ||
                    (rsp_parent_dir == DIR_DOWN))
      else $error("bad parent direction code");

endmodule

bind grid_astar_path_finder gaf_checker u_gaf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_found        (rsp_found),
   .rsp_path_length  (rsp_path_length),
   .rsp_parent_dir   (rsp_parent_dir),
   .rsp_cell_reached (rsp_cell_reached)
);
